FILE: hw/rtl/psd_pkg.sv
// psd_pkg: widths, case codes and item types shared by the
// point-to-segment distance pipeline; no dependencies
`default_nettype none

package psd_pkg;

    // coordinate format
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_BITS  = COORD_BITS + 1;

    // internal widths
    localparam int DIFF_W = COORD_BITS + 1;          // v and w components
    localparam int PROD_W = 2 * DIFF_W;              // single products
    localparam int VV_W   = PROD_W;                  // |v|^2, unsigned
    localparam int DOT_W  = PROD_W + 1;              // w.v, signed
    localparam int T_FRAC = 16;                      // fraction bits of t
    localparam int T_W    = T_FRAC + 1;              // t in 0..1.0
    localparam int OFF_W  = T_W + 1 + DIFF_W;        // t * v product
    localparam int DX_W   = COORD_BITS + 3;          // residual vector
    localparam int SQ_W   = 2 * DX_W;                // squared magnitude
    localparam int ROOT_STEPS = SQ_W / 2;            // one root bit a stage
    localparam int RW     = SQ_W + 1;                // root datapath

    typedef enum logic [1:0] {
        CASE_INTERIOR = 2'd0,
        CASE_START    = 2'd1,
        CASE_END      = 2'd2,
        CASE_DEGEN    = 2'd3
    } case_code_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } query_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic [1:0]           case_code;
    } result_t;

    // vectors carried alongside the division
    typedef struct packed {
        logic signed [DIFF_W-1:0] wx;
        logic signed [DIFF_W-1:0] wy;
        logic signed [DIFF_W-1:0] vx;
        logic signed [DIFF_W-1:0] vy;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [VV_W-1:0]         vv;
        logic signed [DOT_W-1:0] dot;
    } front_t;

    typedef struct packed {
        side_t            side;
        case_code_t       code;
        logic [T_W-1:0]   t;
    } proj_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psd_front.sv
// psd_front: differences, products, |v|^2 and w.v over three stages
// depends on psd_pkg
`default_nettype none

module psd_front
    import psd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire query_t query,
    output logic        out_valid,
    output front_t      out_data
);

    logic  v1_reg, v2_reg, v3_reg;
    side_t s1_reg, s2_reg;
    logic signed [PROD_W-1:0] vxx_reg, vyy_reg, wvx_reg, wvy_reg;
    front_t f3_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: segment and point vectors from the start point
    always_ff @(posedge clk)
    begin
        s1_reg.vx <= DIFF_W'(query.bx) - DIFF_W'(query.ax);
        s1_reg.vy <= DIFF_W'(query.by) - DIFF_W'(query.ay);
        s1_reg.wx <= DIFF_W'(query.px) - DIFF_W'(query.ax);
        s1_reg.wy <= DIFF_W'(query.py) - DIFF_W'(query.ay);
    end

    // stage 2: four products
    always_ff @(posedge clk)
    begin
        s2_reg  <= s1_reg;
        vxx_reg <= s1_reg.vx * s1_reg.vx;
        vyy_reg <= s1_reg.vy * s1_reg.vy;
        wvx_reg <= s1_reg.wx * s1_reg.vx;
        wvy_reg <= s1_reg.wy * s1_reg.vy;
    end

    // stage 3: sums
    always_ff @(posedge clk)
    begin
        f3_reg.side <= s2_reg;
        f3_reg.vv   <= VV_W'(unsigned'(vxx_reg)) + VV_W'(unsigned'(vyy_reg));
        f3_reg.dot  <= DOT_W'(wvx_reg) + DOT_W'(wvy_reg);
    end

    assign out_valid = v3_reg;
    assign out_data  = f3_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/psd_div.sv
// psd_div: case decision and pipelined restoring division for t
// one quotient bit per stage; depends on psd_pkg
`default_nettype none

module psd_div
    import psd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire front_t in_data,
    output logic        out_valid,
    output proj_t       out_data
);

    logic                valid_reg [0:T_FRAC];
    logic [VV_W-1:0]     rem_reg   [0:T_FRAC];
    logic [VV_W-1:0]     vv_reg    [0:T_FRAC];
    logic [T_W-1:0]      t_reg     [0:T_FRAC];
    side_t               side_reg  [0:T_FRAC];
    case_code_t          code_reg  [0:T_FRAC];

    logic signed [DOT_W-1:0] vv_s;
    case_code_t              code0;
    logic                    full0;

    // classify the projection and take the integer bit of t
    always_comb
    begin
        vv_s  = signed'({1'b0, in_data.vv});
        full0 = (in_data.dot == vv_s);
        if (in_data.vv == '0)
            code0 = CASE_DEGEN;
        else if (in_data.dot < 0)
            code0 = CASE_START;
        else if (in_data.dot > vv_s)
            code0 = CASE_END;
        else
            code0 = CASE_INTERIOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_data.side;
        vv_reg[0]   <= in_data.vv;
        code_reg[0] <= code0;
        if (code0 == CASE_INTERIOR && !full0)
            rem_reg[0] <= in_data.dot[VV_W-1:0];
        else
            rem_reg[0] <= '0;
        t_reg[0] <= T_W'(code0 == CASE_INTERIOR && full0);
    end

    // fraction bits of t
    for (genvar i = 1; i <= T_FRAC; i++)
    begin : g_step
        logic [VV_W:0] shifted;
        logic          ge;

        assign shifted = {rem_reg[i-1], 1'b0};
        assign ge      = (shifted >= {1'b0, vv_reg[i-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else
                valid_reg[i] <= valid_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            side_reg[i] <= side_reg[i-1];
            vv_reg[i]   <= vv_reg[i-1];
            code_reg[i] <= code_reg[i-1];
            if (ge)
                rem_reg[i] <= VV_W'(shifted - {1'b0, vv_reg[i-1]});
            else
                rem_reg[i] <= shifted[VV_W-1:0];
            t_reg[i] <= {t_reg[i-1][T_W-2:0], ge};
        end
    end

    assign out_valid     = valid_reg[T_FRAC];
    assign out_data.side = side_reg[T_FRAC];
    assign out_data.code = code_reg[T_FRAC];
    assign out_data.t    = t_reg[T_FRAC];

endmodule

`default_nettype wire

FILE: hw/rtl/psd_sqrt.sv
// psd_sqrt: pipelined digit-by-digit integer square root, one root bit
// per stage, case code carried alongside; depends on psd_pkg
`default_nettype none

module psd_sqrt
    import psd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [SQ_W-1:0]  radicand,
    input  wire case_code_t       in_code,
    output logic                  out_valid,
    output logic [RW-1:0]         root,
    output case_code_t            out_code
);

    logic          valid_reg [0:ROOT_STEPS];
    logic [RW-1:0] n_reg     [0:ROOT_STEPS];
    logic [RW-1:0] root_reg  [0:ROOT_STEPS];
    case_code_t    code_reg  [0:ROOT_STEPS];

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        n_reg[0]    <= RW'(radicand);
        root_reg[0] <= '0;
        code_reg[0] <= in_code;
    end

    // one trial subtraction per stage, highest power of four first
    for (genvar k = 1; k <= ROOT_STEPS; k++)
    begin : g_step
        localparam logic [RW-1:0] BITV = RW'(1) << (2 * (ROOT_STEPS - k));
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = root_reg[k-1] + BITV;
        assign ge    = (n_reg[k-1] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            code_reg[k] <= code_reg[k-1];
            if (ge)
            begin
                n_reg[k]    <= n_reg[k-1] - trial;
                root_reg[k] <= (root_reg[k-1] >> 1) + BITV;
            end
            else
            begin
                n_reg[k]    <= n_reg[k-1];
                root_reg[k] <= root_reg[k-1] >> 1;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_STEPS];
    assign root      = root_reg[ROOT_STEPS];
    assign out_code  = code_reg[ROOT_STEPS];

endmodule

`default_nettype wire

FILE: hw/rtl/point_segment_distance.sv
// point_segment_distance: top level, front end, divider, projection,
// squaring and square root pipeline; depends on psd_pkg and submodules
//
//  channel   ports                      handshake
//  query     start, busy, query         accepted when start && !busy
//  result    done, result               one cycle, done high, no stall
//
// one item may enter every cycle; busy is always low
// items pass the front end, the 17-stage divider for t, the
// projection stages and the 28-stage root pipeline behind them
// reset clears only the valid bits; items in flight are dropped
// the receiver cannot stall, so nothing is ever held back
`default_nettype none

module point_segment_distance
    import psd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire query_t query,
    output logic        done,
    output result_t     result
);

    logic   front_valid, div_valid, root_valid;
    front_t front_data;
    proj_t  proj;

    logic                     p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    proj_t                    p1_reg;
    logic signed [OFF_W-1:0]  offx_reg, offy_reg;
    logic signed [DX_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    case_code_t               c2_reg, c3_reg, c4_reg, root_code;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sum_reg;
    logic [RW-1:0]            root;
    logic signed [OFF_W-1:0]  shx, shy;
    side_t                    s1;

    assign busy = 1'b0;

    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .query     (query),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    psd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (proj)
    );

    // valid bits of the projection stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= div_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    // projection offset t * v
    always_ff @(posedge clk)
    begin
        p1_reg   <= proj;
        offx_reg <= signed'({1'b0, proj.t}) * proj.side.vx;
        offy_reg <= signed'({1'b0, proj.t}) * proj.side.vy;
    end

    assign s1 = p1_reg.side;

    // floor shift of the offset and residual vector per case
    always_comb
    begin
        shx = offx_reg >>> T_FRAC;
        shy = offy_reg >>> T_FRAC;
        case (p1_reg.code)
            CASE_INTERIOR:
            begin
                dx_next = DX_W'(s1.wx) - DX_W'(shx);
                dy_next = DX_W'(s1.wy) - DX_W'(shy);
            end
            CASE_END:
            begin
                dx_next = DX_W'(s1.wx) - DX_W'(s1.vx);
                dy_next = DX_W'(s1.wy) - DX_W'(s1.vy);
            end
            default:
            begin
                dx_next = DX_W'(s1.wx);
                dy_next = DX_W'(s1.wy);
            end
        endcase
    end

    // residual, squares, sum
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        c2_reg  <= p1_reg.code;
        sqx_reg <= unsigned'(SQ_W'(dx_reg * dx_reg));
        sqy_reg <= unsigned'(SQ_W'(dy_reg * dy_reg));
        c3_reg  <= c2_reg;
        sum_reg <= sqx_reg + sqy_reg;
        c4_reg  <= c3_reg;
    end

    psd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p4_valid_reg),
        .radicand  (sum_reg),
        .in_code   (c4_reg),
        .out_valid (root_valid),
        .root      (root),
        .out_code  (root_code)
    );

    assign done             = root_valid;
    assign result.distance  = root[DIST_BITS-1:0];
    assign result.case_code = root_code;

endmodule

`default_nettype wire
